FILE: rtl/cst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the comment-stripping tokenizer.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int WS_DEPTH = 16;
    localparam int WS_CNT_W = $clog2(WS_DEPTH + 1);
    localparam int WS_IDX_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
    localparam int WS_W     = 6;

    localparam int BYTE_W   = 8;
    localparam int MASK_W   = 64;
    localparam int CFG_IDX_W = 1;
    localparam int USER_W   = 2;

    localparam logic [MASK_W-1:0] STOP_LOW_RESET  = 64'h0800_0001_0000_2600;
    localparam logic [MASK_W-1:0] STOP_HIGH_RESET = 64'h0;

    localparam logic [BYTE_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] WS_MAX   = 8'd32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STOP_LOW  = 1'b0,
        REG_STOP_HIGH = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CM_PLAIN = 3'd0,
        CM_SLASH = 3'd1,
        CM_LINE  = 3'd2,
        CM_BLOCK = 3'd3,
        CM_STAR  = 3'd4
    } comment_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLASH,
        ST_MAIN,
        ST_EOB
    } ctl_state_t;

    typedef struct packed {
        logic accept;
        logic emit_flush;
        logic emit_byte;
        logic byte_is_slash;
        logic emit_end;
        logic end_tok;
        logic hold_ws;
        logic last;
    } cst_cmd_t;

    typedef struct packed {
        logic do_slash;
        logic do_plain;
        logic do_end;
        logic eob;
        logic c_stop;
        logic c_ws;
        logic started;
        logic flush_more;
        logic out_free;
    } cst_status_t;

endpackage

FILE: rtl/cst_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_ctrl
// Sequencer: walks each accepted byte through the pending-slash, main and
// end-of-buffer steps, issuing flush, emit, hold and end commands.
// ----------------------------------------------------------------------------
module cst_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  cst_pkg::cst_status_t sts,
    output cst_pkg::cst_cmd_t    cmd
);
    import cst_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_SLASH;
                end
            end
            ST_SLASH: begin
                if (!sts.do_slash) begin
                    state_next = ST_MAIN;
                end else if (sts.out_free) begin
                    if (sts.flush_more) begin
                        cmd.emit_flush = 1'b1;
                    end else begin
                        cmd.emit_byte     = 1'b1;
                        cmd.byte_is_slash = 1'b1;
                        cmd.last          = !sts.c_stop && sts.c_ws && !sts.eob;
                        state_next        = ST_MAIN;
                    end
                end
            end
            ST_MAIN: begin
                if ((sts.do_plain && sts.c_stop) || sts.do_end) begin
                    if (!sts.started) begin
                        cmd.end_tok = 1'b1;
                        state_next  = ST_EOB;
                    end else if (sts.out_free) begin
                        cmd.emit_end = 1'b1;
                        cmd.end_tok  = 1'b1;
                        cmd.last     = 1'b1;
                        state_next   = ST_EOB;
                    end
                end else if (sts.do_plain && sts.c_ws) begin
                    cmd.hold_ws = 1'b1;
                    state_next  = ST_EOB;
                end else if (sts.do_plain) begin
                    if (sts.out_free) begin
                        if (sts.flush_more) begin
                            cmd.emit_flush = 1'b1;
                        end else begin
                            cmd.emit_byte = 1'b1;
                            cmd.last      = !sts.eob;
                            state_next    = ST_EOB;
                        end
                    end
                end else begin
                    state_next = ST_EOB;
                end
            end
            ST_EOB: begin
                if (!sts.eob) begin
                    state_next = ST_IDLE;
                end else if (!sts.started) begin
                    cmd.end_tok = 1'b1;
                    state_next  = ST_IDLE;
                end else if (sts.out_free) begin
                    cmd.emit_end = 1'b1;
                    cmd.end_tok  = 1'b1;
                    cmd.last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/cst_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cst_datapath
// Byte latch and decode, comment mode, stop masks, held whitespace store,
// token state and the output word register.
// ----------------------------------------------------------------------------
module cst_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [cst_pkg::BYTE_W-1:0]     s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [cst_pkg::BYTE_W-1:0]     m_tdata,
    output logic                           m_tlast,
    output logic [cst_pkg::USER_W-1:0]     m_tuser,
    input  logic                           cfg_valid,
    input  logic [cst_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cst_pkg::MASK_W-1:0]     cfg_data,
    input  cst_pkg::cst_cmd_t              cmd,
    output cst_pkg::cst_status_t           sts
);
    import cst_pkg::*;

    logic [MASK_W-1:0]   stop_low_reg, stop_low_next;
    logic [MASK_W-1:0]   stop_high_reg, stop_high_next;
    comment_mode_t       mode_reg, mode_next;
    logic                started_reg, started_next;
    logic                ws_lost_reg, ws_lost_next;
    logic [WS_CNT_W-1:0] held_count_reg, held_count_next;
    logic [WS_CNT_W-1:0] flush_idx_reg, flush_idx_next;
    logic [WS_W-1:0]     held_reg [WS_DEPTH];

    logic [BYTE_W-1:0]   c_reg, c_next;
    logic                eob_reg, eob_next;
    logic                do_slash_reg, do_slash_next;
    logic                do_plain_reg, do_plain_next;
    logic                do_end_reg, do_end_next;

    logic                m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]   m_data_reg, m_data_next;
    logic                m_last_reg, m_last_next;
    logic [USER_W-1:0]   m_user_reg, m_user_next;

    logic                c_stop;
    logic                c_ws;
    logic                out_free;
    logic                held_wr;
    logic [WS_W-1:0]     flush_byte;

    assign c_ws       = (c_reg <= WS_MAX);
    assign out_free   = !m_valid_reg || m_tready;
    assign flush_byte = held_reg[flush_idx_reg[WS_IDX_W-1:0]];

    always_comb begin
        if (!c_reg[7] && !c_reg[6]) begin
            c_stop = stop_low_reg[c_reg[5:0]];
        end else if (!c_reg[7]) begin
            c_stop = stop_high_reg[c_reg[5:0]];
        end else begin
            c_stop = 1'b0;
        end
    end

    always_comb begin
        sts.do_slash   = do_slash_reg;
        sts.do_plain   = do_plain_reg;
        sts.do_end     = do_end_reg;
        sts.eob        = eob_reg;
        sts.c_stop     = c_stop;
        sts.c_ws       = c_ws;
        sts.started    = started_reg;
        sts.flush_more = (flush_idx_reg < held_count_reg);
        sts.out_free   = out_free;
    end

    // decode the incoming byte against the comment mode
    always_comb begin
        c_next        = c_reg;
        eob_next      = eob_reg;
        do_slash_next = do_slash_reg;
        do_plain_next = do_plain_reg;
        do_end_next   = do_end_reg;
        mode_next     = mode_reg;
        if (cmd.accept) begin
            c_next        = s_tdata;
            eob_next      = s_tlast;
            do_slash_next = 1'b0;
            do_plain_next = 1'b0;
            do_end_next   = 1'b0;
            unique case (mode_reg)
                CM_SLASH: begin
                    if (s_tdata == CH_SLASH) begin
                        do_end_next = 1'b1;
                        mode_next   = CM_LINE;
                    end else if (s_tdata == CH_STAR) begin
                        do_end_next = 1'b1;
                        mode_next   = CM_BLOCK;
                    end else begin
                        do_slash_next = 1'b1;
                        do_plain_next = 1'b1;
                        mode_next     = CM_PLAIN;
                    end
                end
                CM_LINE: begin
                    if (s_tdata == CH_LF || s_tdata == CH_CR) begin
                        mode_next = CM_PLAIN;
                    end
                end
                CM_BLOCK: begin
                    if (s_tdata == CH_STAR) begin
                        mode_next = CM_STAR;
                    end
                end
                CM_STAR: begin
                    if (s_tdata == CH_SLASH) begin
                        mode_next = CM_PLAIN;
                    end else if (s_tdata != CH_STAR) begin
                        mode_next = CM_BLOCK;
                    end
                end
                default: begin
                    if (s_tdata == CH_SLASH) begin
                        mode_next = CM_SLASH;
                    end else begin
                        do_plain_next = 1'b1;
                        mode_next     = CM_PLAIN;
                    end
                end
            endcase
            if (s_tlast) begin
                mode_next = CM_PLAIN;
            end
        end
    end

    // token state, whitespace store and output word
    always_comb begin
        started_next    = started_reg;
        ws_lost_next    = ws_lost_reg;
        held_count_next = held_count_reg;
        flush_idx_next  = flush_idx_reg;
        held_wr         = 1'b0;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_last_next     = m_last_reg;
        m_user_next     = m_user_reg;
        stop_low_next   = stop_low_reg;
        stop_high_next  = stop_high_reg;

        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_STOP_LOW:  stop_low_next  = cfg_data;
                REG_STOP_HIGH: stop_high_next = cfg_data;
                default:       stop_low_next  = stop_low_reg;
            endcase
        end

        if (cmd.emit_flush) begin
            m_valid_next   = 1'b1;
            m_data_next    = {{(BYTE_W - WS_W){1'b0}}, flush_byte};
            m_last_next    = 1'b0;
            m_user_next    = {ws_lost_reg, 1'b0};
            flush_idx_next = flush_idx_reg + 1'b1;
        end
        if (cmd.emit_byte) begin
            m_valid_next    = 1'b1;
            m_data_next     = cmd.byte_is_slash ? CH_SLASH : c_reg;
            m_last_next     = cmd.last;
            m_user_next     = {ws_lost_reg, 1'b0};
            held_count_next = '0;
            flush_idx_next  = '0;
            ws_lost_next    = 1'b0;
            started_next    = 1'b1;
        end
        if (cmd.emit_end) begin
            m_valid_next = 1'b1;
            m_data_next  = '0;
            m_last_next  = cmd.last;
            m_user_next  = {1'b0, 1'b1};
        end
        if (cmd.end_tok) begin
            ws_lost_next    = 1'b0;
            started_next    = 1'b0;
            held_count_next = '0;
            flush_idx_next  = '0;
        end
        if (cmd.hold_ws && started_reg) begin
            if (held_count_reg < WS_CNT_W'(WS_DEPTH)) begin
                held_wr         = 1'b1;
                held_count_next = held_count_reg + 1'b1;
            end else begin
                ws_lost_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_low_reg   <= STOP_LOW_RESET;
            stop_high_reg  <= STOP_HIGH_RESET;
            mode_reg       <= CM_PLAIN;
            started_reg    <= 1'b0;
            ws_lost_reg    <= 1'b0;
            held_count_reg <= '0;
            flush_idx_reg  <= '0;
            m_valid_reg    <= 1'b0;
            do_slash_reg   <= 1'b0;
            do_plain_reg   <= 1'b0;
            do_end_reg     <= 1'b0;
            eob_reg        <= 1'b0;
        end else begin
            stop_low_reg   <= stop_low_next;
            stop_high_reg  <= stop_high_next;
            mode_reg       <= mode_next;
            started_reg    <= started_next;
            ws_lost_reg    <= ws_lost_next;
            held_count_reg <= held_count_next;
            flush_idx_reg  <= flush_idx_next;
            m_valid_reg    <= m_valid_next;
            do_slash_reg   <= do_slash_next;
            do_plain_reg   <= do_plain_next;
            do_end_reg     <= do_end_next;
            eob_reg        <= eob_next;
        end
    end

    always_ff @(posedge aclk) begin
        c_reg      <= c_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
        m_user_reg <= m_user_next;
        if (held_wr) begin
            held_reg[held_count_reg[WS_IDX_W-1:0]] <= c_reg[WS_W-1:0];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/comment_stripping_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// comment_stripping_tokenizer
// Splits a byte stream into tokens on stop bytes, strips C-style comments
// and trims whitespace around each token.
// ----------------------------------------------------------------------------
// Each input word is one text byte (tlast marks the last byte of a buffer).
// Output words are token bytes (tuser kind 0) and end-of-token markers
// (tuser kind 1); tlast marks the final output word caused by an input byte.
// A byte passes the four sequencer steps (accept, pending slash, main step,
// end of buffer), held longer by each output word beyond the first, such as
// held whitespace flushed ahead of a token byte, and by output backpressure;
// no new byte is accepted until the last step ends. The user must write the
// stop masks through the cfg port (index 0: bytes 0-63, index 1: bytes 64-127)
// only while the stream is idle; the block itself does not enforce this.
module comment_stripping_tokenizer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [cst_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] in_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [cst_pkg::BYTE_W-1:0]    m_tdata,   // [7:0] value
    output logic                          m_tlast,
    output logic [cst_pkg::USER_W-1:0]    m_tuser,   // [0] kind, [1] ws_dropped
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cst_pkg::MASK_W-1:0]    cfg_data
);
    import cst_pkg::*;

    cst_cmd_t    cmd;
    cst_status_t sts;

    assign cfg_ready = 1'b1;

    cst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cst_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: sim/token_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// token_stream_checker
// Watches the byte, token and stop-mask channels of the tokenizer. It keeps
// its own copy of the comment state, held whitespace and stop masks, works
// out the token words each accepted text byte causes, and compares every
// accepted output word with the oldest outstanding word.
// ----------------------------------------------------------------------------
module token_stream_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [cst_pkg::BYTE_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [cst_pkg::BYTE_W-1:0]    m_tdata,
    input  logic                          m_tlast,
    input  logic [cst_pkg::USER_W-1:0]    m_tuser,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [cst_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cst_pkg::MASK_W-1:0]    cfg_data,
    output int                            fail_count,
    output int                            pending_count,
    output int                            words_checked
);
    import cst_pkg::*;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] value;
        logic              last;
        logic              ws_dropped;
    } token_word_t;

    token_word_t       token_words_due[$];
    token_word_t       step_words[$];

    logic [MASK_W-1:0] stop_low;
    logic [MASK_W-1:0] stop_high;
    comment_mode_t     mode;
    logic              in_token;
    logic              ws_lost;
    logic [WS_W-1:0]   held_ws [WS_DEPTH];
    int                held_n;
    int                fails;
    int                checked;

    function automatic logic is_stop_byte(input logic [BYTE_W-1:0] c);
        if (c < 8'd64)
            return stop_low[c[5:0]];
        else if (c < 8'd128)
            return stop_high[c[5:0]];
        return 1'b0;
    endfunction

    task automatic emit_word(input logic kind, input logic [BYTE_W-1:0] value);
        token_word_t w;
        w.kind       = kind;
        w.value      = value;
        w.last       = 1'b0;
        w.ws_dropped = ws_lost;
        step_words   = {step_words, w};
    endtask

    task automatic close_token();
        ws_lost = 1'b0;
        if (in_token)
            emit_word(1'b1, 8'h00);
        in_token = 1'b0;
        held_n   = 0;
    endtask

    task automatic take_text_byte(input logic [BYTE_W-1:0] c);
        if (c <= WS_MAX) begin
            if (in_token) begin
                if (held_n < WS_DEPTH) begin
                    held_ws[held_n] = c[WS_W-1:0];
                    held_n++;
                end else begin
                    ws_lost = 1'b1;
                end
            end
        end else begin
            for (int i = 0; i < held_n; i++)
                emit_word(1'b0, BYTE_W'(held_ws[i]));
            held_n = 0;
            emit_word(1'b0, c);
            ws_lost  = 1'b0;
            in_token = 1'b1;
        end
    endtask

    task automatic plain_text_byte(input logic [BYTE_W-1:0] c);
        if (is_stop_byte(c))
            close_token();
        else
            take_text_byte(c);
    endtask

    task automatic tokenize_byte(input logic [BYTE_W-1:0] c, input logic eob);
        step_words.delete();
        case (mode)
            CM_PLAIN: begin
                if (c == CH_SLASH)
                    mode = CM_SLASH;
                else
                    plain_text_byte(c);
            end
            CM_SLASH: begin
                if (c == CH_SLASH) begin
                    close_token();
                    mode = CM_LINE;
                end else if (c == CH_STAR) begin
                    close_token();
                    mode = CM_BLOCK;
                end else begin
                    mode = CM_PLAIN;
                    take_text_byte(CH_SLASH);
                    plain_text_byte(c);
                end
            end
            CM_LINE: begin
                if (c == CH_LF || c == CH_CR)
                    mode = CM_PLAIN;
            end
            CM_BLOCK: begin
                if (c == CH_STAR)
                    mode = CM_STAR;
            end
            default: begin
                if (c == CH_SLASH)
                    mode = CM_PLAIN;
                else if (c != CH_STAR)
                    mode = CM_BLOCK;
            end
        endcase
        if (eob) begin
            close_token();
            mode = CM_PLAIN;
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last = 1'b1;
        token_words_due = {token_words_due, step_words};
        step_words.delete();
    endtask

    always @(posedge aclk) begin
        token_word_t w;
        if (!aresetn) begin
            stop_low  = STOP_LOW_RESET;
            stop_high = STOP_HIGH_RESET;
            mode      = CM_PLAIN;
            in_token  = 1'b0;
            ws_lost   = 1'b0;
            held_n    = 0;
            fails     = 0;
            checked   = 0;
            token_words_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_STOP_LOW)
                    stop_low = cfg_data;
                else if (cfg_index == REG_STOP_HIGH)
                    stop_high = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                checked++;
                if (token_words_due.size() == 0) begin
                    $error("unexpected output word: value %0h kind %0d",
                           m_tdata, m_tuser[0]);
                    fails++;
                end else begin
                    w = token_words_due[0];
                    token_words_due.delete(0);
                    if (m_tuser[0] !== w.kind) begin
                        $error("kind mismatch: expected %0d, got %0d", w.kind, m_tuser[0]);
                        fails++;
                    end
                    if (m_tdata !== w.value) begin
                        $error("value mismatch: expected %0h, got %0h", w.value, m_tdata);
                        fails++;
                    end
                    if (m_tlast !== w.last) begin
                        $error("last mismatch: expected %0d, got %0d", w.last, m_tlast);
                        fails++;
                    end
                    if (m_tuser[1] !== w.ws_dropped) begin
                        $error("ws_dropped mismatch: expected %0d, got %0d",
                               w.ws_dropped, m_tuser[1]);
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                tokenize_byte(s_tdata, s_tlast);
        end
        fail_count    <= fails;
        pending_count <= token_words_due.size();
        words_checked <= checked;
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the comment-stripping tokenizer. A directed
// run of buffers covers trimming, lone slashes and both comment kinds; random text
// made of words, whitespace runs, comments and noise then runs under several
// stop-mask settings, with random stalls on both sides and one long output
// hold-off. A separate checker predicts and compares every output word.
// ----------------------------------------------------------------------------
module testbench;
    import cst_pkg::*;

    localparam int LONG_STALL   = 250;
    localparam int SETTLE       = 40;
    localparam int IDLE_LIMIT   = 2000;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [BYTE_W-1:0]    m_tdata;
    logic                 m_tlast;
    logic [USER_W-1:0]    m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [MASK_W-1:0]    cfg_data;

    int fail_count;
    int pending_count;
    int words_checked;
    int bytes_sent;
    int buffers_sent;
    int idle_cycles;
    bit quiet;
    bit long_stall_req;

    comment_stripping_tokenizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    token_stream_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .words_checked (words_checked)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eob);
        s_tdata  <= b;
        s_tlast  <= eob;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        bytes_sent++;
        if (eob)
            buffers_sent++;
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic put_byte(input logic [BYTE_W-1:0] b);
        send_byte(b, $urandom_range(0, 14) == 0);
    endtask

    function automatic logic [BYTE_W-1:0] text_char();
        if ($urandom_range(0, 5) == 0)
            return BYTE_W'($urandom_range(128, 255));
        return BYTE_W'($urandom_range(33, 126));
    endfunction

    task automatic send_segment();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                n = $urandom_range(1, 6);
                repeat (n) put_byte(text_char());
            end
            3: begin
                n = $urandom_range(1, 22);
                repeat (n) put_byte(BYTE_W'($urandom_range(0, 32)));
            end
            4: begin
                put_byte(CH_SLASH);
                put_byte(CH_SLASH);
                n = $urandom_range(0, 4);
                repeat (n) put_byte(BYTE_W'($urandom_range(0, 255)));
                put_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
            end
            5: begin
                put_byte(CH_SLASH);
                put_byte(CH_STAR);
                n = $urandom_range(0, 4);
                repeat (n) put_byte(BYTE_W'($urandom_range(0, 255)));
                put_byte(CH_STAR);
                put_byte(CH_SLASH);
            end
            6: begin
                put_byte(CH_SLASH);
                put_byte(text_char());
            end
            7: put_byte(BYTE_W'($urandom_range(0, 127)));
            8: put_byte(BYTE_W'($urandom_range(0, 255)));
            default: begin
                put_byte(CH_SLASH);
                put_byte(CH_STAR);
                put_byte(BYTE_W'($urandom_range(0, 255)));
                put_byte(CH_STAR);
            end
        endcase
    endtask

    task automatic send_text(input int n);
        int target;
        target = bytes_sent + n;
        while (bytes_sent < target)
            send_segment();
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [MASK_W-1:0] d);
        cfg_index <= idx;
        cfg_data  <= d;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // receiver: random bursts of hold-off, one long stretch on request
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (long_stall_req) begin
                long_stall_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (!quiet && aresetn && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= aresetn;
            end
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no word accepted for %0d cycles", IDLE_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [MASK_W-1:0] ws_bits;
        ws_bits        = 64'h0000_0001_FFFF_FFFF;
        quiet          = 1'b0;
        long_stall_req = 1'b0;
        bytes_sent     = 0;
        buffers_sent   = 0;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_STOP_LOW;
        cfg_data  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset masks: trimming, high bytes, lone slash, both comment kinds
        send_byte(8'h00, 1'b0);
        send_byte("x", 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte("y", 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(";", 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte("q", 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte("z", 1'b0);
        send_byte(CH_LF, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte("k", 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte(CH_SLASH, 1'b0);
        send_byte("m", 1'b0);
        send_byte(CH_SLASH, 1'b1);
        send_byte(CH_SLASH, 1'b0);
        send_byte(CH_STAR, 1'b0);
        send_byte("c", 1'b1);
        drain();

        // every byte below 128 stops
        write_reg(REG_STOP_LOW, '1);
        write_reg(REG_STOP_HIGH, '1);
        send_text(22);
        drain();

        // nothing stops: long whitespace runs overflow the hold buffer
        write_reg(REG_STOP_LOW, '0);
        write_reg(REG_STOP_HIGH, '0);
        send_text(22);
        drain();

        // slash and star marked as stops, the rest random; long output hold-off
        write_reg(REG_STOP_LOW, {$urandom, $urandom} | (64'd1 << CH_SLASH) | (64'd1 << CH_STAR));
        write_reg(REG_STOP_HIGH, {$urandom, $urandom});
        send_text(8);
        long_stall_req = 1'b1;
        send_text(18);
        drain();

        // whitespace never stops, random printable stops
        write_reg(REG_STOP_LOW, ({$urandom, $urandom} & ~ws_bits) | (64'd1 << 59));
        write_reg(REG_STOP_HIGH, {$urandom, $urandom});
        send_text(10);
        quiet = 1'b1;
        send_text(15);
        drain();

        $display("covered %0d text bytes in %0d buffers under five stop-mask settings",
                 bytes_sent, buffers_sent);
        $display("checked %0d output words", words_checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/cst_pkg.sv
rtl/cst_ctrl.sv
rtl/cst_datapath.sv
rtl/comment_stripping_tokenizer.sv
sim/token_stream_checker.sv
sim/testbench.sv
